// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
// No dependencies; every other file imports this package.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    localparam int CHAR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int ADDR_W  = 11;
    localparam int WORD_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Control bytes
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam logic [CHAR_W-1:0] CR_CHAR   = 8'hFF;
    localparam logic [CHAR_W-1:0] BLANK_CHR = 8'h00;
    localparam logic [CHAR_W-1:0] BLANK_ATR = 8'h0F;
    localparam int               TAB_STEP  = 4;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_TAB,
        OP_BS,
        OP_CR,
        OP_NL,
        OP_VT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } t_result;

endpackage

// ===== sv/text_console_char_writer_core.sv =====
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.

// Text console character writer: each input item (character byte and
// attribute byte) yields exactly one result item with an optional cell write
// (write_enable in tuser, address row*COLUMNS+column, word attribute:char)
// and the cursor after the item. Vertical tab is ignored, tab moves four
// columns, newline goes to column 0 of the next row, carriage return writes
// 0xFF with attribute (row*column) low byte and then does a newline,
// backspace above column 0 steps back and blanks the cell with 0x0F00.
// Other bytes are written at the cursor, which moves right, or left when
// right_to_left is set. The block takes one item per cycle and delivers one
// result per cycle while the receiver keeps taking results; an accepted item
// is written into the queue and then loaded into the output register. The
// per-item cursor update (one add/compare chain and a 5x7 product in the
// back end) is combinational, so the back end keeps that rate. A four-entry
// queue parts the input side from the output register, so input keeps
// flowing until four items wait behind a stalled result.
module text_console_char_writer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: right_to_left in bit 0
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] char_code, [15:8] attribute
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [10:0] cell_address, [26:11] cell_word, [33:27] cursor_column,
    // [38:34] cursor_row, [39] zero
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser    // [0] write_enable
);
    import tcw_pkg::*;

    logic      w_push;
    logic      w_pop;
    t_item     w_push_item;
    t_item     w_head_item;
    t_q_status w_q_status;
    t_result   w_result;

    // Accept and classify
    tcw_front u_front (
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_char     (i_s_axis_tdata[7:0]),
        .i_attr     (i_s_axis_tdata[15:8]),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // Hold classified items until the back end is free
    tcw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    // Advance the cursor and register the result
    tcw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_rtl  (i_cfg_wdata),
        .i_item     (w_head_item),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (w_result)
    );

    assign o_m_axis_tdata = {1'b0, w_result.row, w_result.col, w_result.word, w_result.addr};
    assign o_m_axis_tuser = w_result.we;

endmodule

// ===== sv/tcw_front.sv =====
// Front end: accepts input items and classifies the character byte.
// Depends on tcw_pkg.
module tcw_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_attr,
    input  tcw_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output tcw_pkg::t_item                o_item
);
    import tcw_pkg::*;

    t_op w_op;

    always_comb begin
        case (i_char)
            CH_VT:   w_op = OP_VT;
            CH_TAB:  w_op = OP_TAB;
            CH_BS:   w_op = OP_BS;
            CH_CR:   w_op = OP_CR;
            CH_NL:   w_op = OP_NL;
            default: w_op = OP_PRINT;
        endcase
    end

    assign o_ready     = !i_q_status.full;
    assign o_push      = i_valid && !i_q_status.full;
    assign o_item.op   = w_op;
    assign o_item.ch   = i_char;
    assign o_item.attr = i_attr;

endmodule

// ===== sv/tcw_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on tcw_pkg.
module tcw_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tcw_pkg::t_item     i_item,
    input  logic               i_pop,
    output tcw_pkg::t_item     o_item,
    output tcw_pkg::t_q_status o_status
);
    import tcw_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    t_item             r_head;
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        // Hold the head entry in a register; forward an item that lands at the new head
        if (i_push && (n_rd_ptr == r_wr_ptr)) begin
            r_head <= i_item;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_item         = r_head;
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== sv/tcw_back.sv =====
// Back end: keeps the cursor, carries out one queued item per cycle (unless
// stalled) and holds the result in an output register. Depends on tcw_pkg.
module tcw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_rtl,
    input  tcw_pkg::t_item     i_item,
    input  tcw_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output tcw_pkg::t_result   o_result
);
    import tcw_pkg::*;

    logic             r_rtl;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             r_valid;
    t_result          r_result;

    logic [COL_W:0]    w_col;
    logic [ROW_W:0]    w_row;
    logic [COL_W-1:0]  w_addr_col;
    logic              w_we;
    logic [WORD_W-1:0] w_word;
    logic [ADDR_W-1:0] w_addr;
    logic [COL_W+ROW_W-1:0] w_prod;
    logic              w_load;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    t_result           n_result;

    // Take a new item whenever the output register is free or being drained
    assign w_load = !i_q_status.empty && (!r_valid || i_ready);
    assign o_pop  = w_load;

    assign w_prod = (COL_W+ROW_W)'(r_row) * (COL_W+ROW_W)'(r_col);

    always_comb begin
        w_col      = {1'b0, r_col};
        w_row      = {1'b0, r_row};
        w_addr_col = r_col;
        w_we       = 1'b0;
        w_word     = '0;
        case (i_item.op)
            OP_VT: begin
            end
            OP_TAB: begin
                w_col = {1'b0, r_col} + (COL_W+1)'(TAB_STEP);
            end
            OP_BS: begin
                if (r_col != '0) begin
                    w_col      = {1'b0, r_col} - 1'b1;
                    w_addr_col = r_col - 1'b1;
                    w_we       = 1'b1;
                    w_word     = {BLANK_ATR, BLANK_CHR};
                end
            end
            OP_CR: begin
                w_we   = 1'b1;
                w_word = {w_prod[7:0], CR_CHAR};
                w_col  = '0;
                w_row  = {1'b0, r_row} + 1'b1;
            end
            OP_NL: begin
                w_col = '0;
                w_row = {1'b0, r_row} + 1'b1;
            end
            OP_PRINT: begin
                w_we   = 1'b1;
                w_word = {i_item.attr, i_item.ch};
                if (!r_rtl) begin
                    w_col = {1'b0, r_col} + 1'b1;
                end else if (r_col == '0) begin
                    w_row = {1'b0, r_row} + 1'b1;
                end else begin
                    w_col = {1'b0, r_col} - 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Wrap column into the next row, then row back to the top
        if (w_col >= (COL_W+1)'(COLUMNS)) begin
            w_col = '0;
            w_row = w_row + 1'b1;
        end
        if (w_row >= (ROW_W+1)'(ROWS)) begin
            w_col = '0;
            w_row = '0;
        end
        n_col = w_col[COL_W-1:0];
        n_row = w_row[ROW_W-1:0];
    end

    assign w_addr = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(w_addr_col);

    always_comb begin
        n_result.we   = w_we;
        n_result.addr = w_we ? w_addr : '0;
        n_result.word = w_word;
        n_result.col  = n_col;
        n_result.row  = n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtl   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rtl <= i_cfg_rtl;
            end
            if (w_load) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sim/tb_text_console_char_writer_core.sv =====
// Self-checking testbench for text_console_char_writer_core.
// Depends on tcw_pkg and the RTL of the core. A scoreboard class tracks the cursor
// and checks every result item; plain tasks drive the input and config ports.
module tb_text_console_char_writer_core;
    import tcw_pkg::*;

    // Keeps its own copy of the cursor and the direction bit, predicts one result
    // per accepted character and checks results in order.
    class cursor_scoreboard;
        int unsigned col;
        int unsigned row;
        bit          rtl;
        t_result     cell_writes_q[$];
        int          errors;

        function new();
            col    = 0;
            row    = 0;
            rtl    = 1'b0;
            errors = 0;
        endfunction

        function void set_direction(bit value);
            rtl = value;
        endfunction

        function int pending();
            return cell_writes_q.size();
        endfunction

        // Advance the cursor for one accepted character and queue the result.
        function void note_item(logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr);
            t_result           res;
            logic [CHAR_W-1:0] prod;
            res  = '0;
            prod = '0;
            case (ch)
                CH_VT: begin
                end
                CH_TAB: begin
                    col = col + TAB_STEP;
                end
                CH_BS: begin
                    if (col > 0) begin
                        col      = col - 1;
                        res.we   = 1'b1;
                        res.addr = ADDR_W'(row * COLUMNS + col);
                        res.word = {BLANK_ATR, BLANK_CHR};
                    end
                end
                CH_CR: begin
                    prod     = CHAR_W'(row * col);
                    res.we   = 1'b1;
                    res.addr = ADDR_W'(row * COLUMNS + col);
                    res.word = {prod, CR_CHAR};
                    col      = 0;
                    row      = row + 1;
                end
                CH_NL: begin
                    col = 0;
                    row = row + 1;
                end
                default: begin
                    res.we   = 1'b1;
                    res.addr = ADDR_W'(row * COLUMNS + col);
                    res.word = {attr, ch};
                    if (!rtl) begin
                        col = col + 1;
                    end else if (col == 0) begin
                        row = row + 1;
                    end else begin
                        col = col - 1;
                    end
                end
            endcase
            if (col >= COLUMNS) begin
                col = 0;
                row = row + 1;
            end
            if (row >= ROWS) begin
                col = 0;
                row = 0;
            end
            res.col = COL_W'(col);
            res.row = ROW_W'(row);
            cell_writes_q.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic tuser, logic [39:0] tdata);
            t_result exp_r;
            if (cell_writes_q.size() == 0) begin
                $error("result item with no prediction waiting: tuser=%0b tdata=0x%0h",
                       tuser, tdata);
                errors++;
                return;
            end
            exp_r = cell_writes_q.pop_front();
            compare_field("write_enable", 32'(exp_r.we), 32'(tuser));
            compare_field("cell_address", 32'(exp_r.addr), 32'(tdata[10:0]));
            compare_field("cell_word", 32'(exp_r.word), 32'(tdata[26:11]));
            compare_field("cursor_column", 32'(exp_r.col), 32'(tdata[33:27]));
            compare_field("cursor_row", 32'(exp_r.row), 32'(tdata[38:34]));
            compare_field("tdata pad bit", 32'(0), 32'(tdata[39]));
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 450;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 10;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    cursor_scoreboard sb = new();

    int unsigned cycles     = 0;
    int unsigned sent_items = 0;
    int unsigned rx_items   = 0;
    bit          tx_burst   = 1'b0;   // sender offers back to back when set
    bit          rx_burst   = 1'b0;   // receiver takes back to back when set
    bit          hold_req   = 1'b0;   // ask the receiver for one long stall

    text_console_char_writer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Offer one item after a random gap and hold it until the core takes it.
    // Valid stays high across back-to-back items so it never toggles in one step.
    task automatic send_char(logic [CHAR_W-1:0] ch, logic [CHAR_W-1:0] attr);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {attr, ch};
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(ch, attr);
        sent_items++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drained(int unsigned tail);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Write the direction register; only called with the core idle.
    task automatic write_direction(bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_direction(value);
        cfg_we <= 1'b0;
    endtask

    // Draw one random item. Dense text rarely breaks the line so the cursor
    // runs into the right edge; mixed text breaks lines often so rows wrap.
    task automatic pick_item(bit dense, output logic [CHAR_W-1:0] ch,
                             output logic [CHAR_W-1:0] attr);
        int unsigned r;
        r    = $urandom_range(0, 99);
        attr = CHAR_W'($urandom_range(0, 255));
        ch   = CHAR_W'($urandom_range(0, 255));
        if (dense) begin
            if (r < 1)       ch = CH_NL;
            else if (r < 2)  ch = CH_CR;
            else if (r < 27) ch = CH_TAB;
            else if (r < 33) ch = CH_BS;
            else if (r < 35) ch = CH_VT;
        end else begin
            if (r < 12)      ch = CH_NL;
            else if (r < 20) ch = CH_CR;
            else if (r < 28) ch = CH_TAB;
            else if (r < 36) ch = CH_BS;
            else if (r < 40) ch = CH_VT;
        end
    endtask

    // Watchdog: a hung handshake ends the run here.
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random ready gaps, bursts of back-to-back takes, and one long
    // stall on request so the internal queue fills and the input side stalls.
    initial begin
        int unsigned gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 11);
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
            sb.check_result(m_tuser, m_tdata);
            rx_items++;
            if (rx_items % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int unsigned       seg;
        int unsigned       seg_len;
        bit                dense;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;

        // Hold reset low, then release it for good.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, left to right: extreme bytes, backspace down to and
        // at column zero, ignored vertical tab, tab, carriage return, newline.
        write_direction(1'b0);
        send_char(8'h00, 8'h00);
        send_char(8'hFF, 8'hFF);
        send_char(8'h7F, 8'h80);
        send_char(CH_BS, 8'hAA);
        send_char(CH_BS, 8'h55);
        send_char(CH_BS, 8'h00);
        send_char(CH_BS, 8'hFF);
        send_char(CH_VT, 8'hFF);
        send_char(CH_TAB, 8'h00);
        send_char(CH_CR, 8'h12);
        send_char(CH_TAB, 8'h34);
        send_char(8'h20, 8'h07);
        send_char(CH_CR, 8'h00);
        send_char(CH_NL, 8'hC3);
        wait_drained(2);

        // Right to left: a character at column zero moves to the next row,
        // backspace still steps left and blanks the cell.
        write_direction(1'b1);
        send_char(8'h42, 8'h1F);
        send_char(CH_TAB, 8'h00);
        send_char(8'h43, 8'hF0);
        send_char(CH_BS, 8'h3C);
        send_char(CH_BS, 8'h00);
        send_char(8'h44, 8'h01);
        send_char(8'h45, 8'hFE);
        send_char(CH_VT, 8'h00);
        wait_drained(2);
        write_direction(1'b0);

        // Random segments; each one starts idle with a fresh direction setting.
        // The third segment runs flat out against a long receiver stall.
        seg = 0;
        while (sent_items < ITEM_TARGET) begin
            wait_drained(2);
            write_direction(bit'($urandom_range(0, 1)));
            dense   = bit'($urandom_range(0, 1));
            seg_len = $urandom_range(30, 70);
            if (seg == 2) begin
                tx_burst = 1'b1;
                seg_len  = 60;
                hold_req = 1'b1;
            end else begin
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            repeat (seg_len) begin
                pick_item(dense, ch, attr);
                send_char(ch, attr);
            end
            seg++;
        end

        // Drain, wait out the tail, then report.
        wait_drained(TAIL_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
